/* hdl/pfa_pkg.sv */
// pfa_pkg: shared codes and types for the texel-to-ARGB8888 converter.
// No dependencies; imported by pfa_unpack, pixel_format_to_argb8888_top and the bench.
package pfa_pkg;

	// source format codes
	localparam logic [4:0] FMT_R8G8B8        = 5'd0;
	localparam logic [4:0] FMT_A8R8G8B8      = 5'd1;
	localparam logic [4:0] FMT_X8R8G8B8      = 5'd2;
	localparam logic [4:0] FMT_R3G3B2        = 5'd3;
	localparam logic [4:0] FMT_A8            = 5'd4;
	localparam logic [4:0] FMT_A8R3G3B2      = 5'd5;
	localparam logic [4:0] FMT_A2B10G10R10   = 5'd6;
	localparam logic [4:0] FMT_A8B8G8R8      = 5'd7;
	localparam logic [4:0] FMT_X8B8G8R8      = 5'd8;
	localparam logic [4:0] FMT_G16R16        = 5'd9;
	localparam logic [4:0] FMT_A2R10G10B10   = 5'd10;
	localparam logic [4:0] FMT_A16B16G16R16  = 5'd11;
	localparam logic [4:0] FMT_A8L8          = 5'd12;
	localparam logic [4:0] FMT_A8P8          = 5'd13;
	localparam logic [4:0] FMT_L8            = 5'd14;
	localparam logic [4:0] FMT_P8            = 5'd15;
	localparam logic [4:0] FMT_L16           = 5'd16;
	localparam logic [4:0] FMT_A4L4          = 5'd17;

	localparam logic [4:0] FMT_RESET = FMT_A8R8G8B8;

	// input item kinds (tuser)
	localparam logic ACT_PAL_WRITE = 1'b0;
	localparam logic ACT_CONVERT   = 1'b1;

	// configuration register indexes
	localparam logic CFG_FORMAT      = 1'b0;
	localparam logic CFG_USE_PALETTE = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// palette lookup control handed from the unpack stage to the merge stage
	typedef struct packed {
		logic       use_ram;   // result comes from the palette store
		logic       alpha_b1;  // replace looked-up alpha by texel byte 1
		logic [7:0] alpha;     // texel byte 1
	} pfa_lookup_t;

endpackage

/* hdl/pfa_ram.sv */
// pfa_ram: generic single-port RAM, one access per cycle, registered read.
// No dependencies.
module pfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

/* hdl/pfa_unpack.sv */
// pfa_unpack: format decode of one raw texel into ARGB8888 (combinational).
// Depends on pfa_pkg. Paletted formats only flag the lookup here.
module pfa_unpack (
	input  logic [4:0]          fmt,
	input  logic                use_palette,
	input  logic [63:0]         pixel_word,
	output logic [31:0]         color,
	output pfa_pkg::pfa_lookup_t lookup
);
	import pfa_pkg::*;

	logic [31:0] lo;
	logic [7:0]  b0, b1;
	logic [7:0]  a2;
	logic [7:0]  r332, g332, b332;
	logic [7:0]  a4, l4;
	logic [31:0] grey0;
	logic        is_pal;

	assign lo = pixel_word[31:0];
	assign b0 = pixel_word[7:0];
	assign b1 = pixel_word[15:8];
	assign a2 = {4{lo[31:30]}};
	// 3:3:2 widened by bit replication
	assign r332 = {b0[7:5], b0[7:5], b0[7:6]};
	assign g332 = {b0[4:2], b0[4:2], b0[4:3]};
	assign b332 = {4{b0[1:0]}};
	assign a4 = {2{b0[7:4]}};
	assign l4 = {2{b0[3:0]}};
	assign grey0 = {ALPHA_OPAQUE, b0, b0, b0};

	assign is_pal = (fmt == FMT_P8) || (fmt == FMT_A8P8);
	assign lookup.use_ram  = is_pal && use_palette;
	assign lookup.alpha_b1 = (fmt == FMT_A8P8);
	assign lookup.alpha    = b1;

	always_comb begin
		unique case (fmt)
			FMT_R8G8B8, FMT_X8R8G8B8: color = {ALPHA_OPAQUE, lo[23:0]};
			FMT_A8R8G8B8:     color = lo;
			FMT_R3G3B2:       color = {ALPHA_OPAQUE, r332, g332, b332};
			FMT_A8:           color = {b0, 24'hFF_FFFF};
			FMT_A8R3G3B2:     color = {b1, r332, g332, b332};
			FMT_A2B10G10R10:  color = {a2, lo[9:2], lo[19:12], lo[29:22]};
			FMT_A8B8G8R8:     color = {lo[31:24], lo[7:0], lo[15:8], lo[23:16]};
			FMT_X8B8G8R8:     color = {ALPHA_OPAQUE, lo[7:0], lo[15:8], lo[23:16]};
			FMT_G16R16:       color = {ALPHA_OPAQUE, lo[15:8], lo[31:24], 8'h00};
			FMT_A2R10G10B10:  color = {a2, lo[29:22], lo[19:12], lo[9:2]};
			FMT_A16B16G16R16: color = {pixel_word[63:56], b1, pixel_word[31:24],
			                           pixel_word[47:40]};
			FMT_A8L8, FMT_A8P8: color = {b1, b0, b0, b0};
			FMT_L8, FMT_P8:   color = grey0;
			FMT_L16:          color = {ALPHA_OPAQUE, b1, b1, b1};
			FMT_A4L4:         color = {a4, l4, l4, l4};
			default:          color = 32'h0;
		endcase
	end

endmodule

/* hdl/pixel_format_to_argb8888_top.sv */
// pixel_format_to_argb8888_top: texel stream to ARGB8888 stream converter.
// Depends on pfa_pkg, pfa_unpack, pfa_ram.
//
//  channel   | direction | transfer contents
//  s_axis    | in        | tuser: action; tdata: pixel_word, entry_index, entry_color
//  m_axis    | out       | tdata: argb
//  cfg       | in        | cfg_we, cfg_index, cfg_wdata (format_select, use_palette)
//
// One texel per clock sustained while the sink does not stall; output comes from s3.
// Stages: s1 input register, s2 format decode + palette RAM read, s3 merge.
// A palette write travels as a bubble and gives no output transfer.
// Reset clears valid bits and config; palette contents are unknown until written.
// Output stalls fill a one-entry skid buffer; s_axis_tready drops only while it holds.
module pixel_format_to_argb8888_top #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [103:0]  s_axis_tdata,  // pixel_word[63:0], entry_index[71:64], entry_color[103:72]
	input  logic          s_axis_tuser,  // action
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,  // argb
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [4:0]    cfg_wdata
);
	import pfa_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

	logic [4:0]  fmt_q;
	logic        use_pal_q;

	logic        en;
	logic        valid_s1, action_s1;
	logic [63:0] pixel_s1;
	logic [7:0]  index_s1;
	logic [31:0] entry_s1;

	logic        ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_rdata;

	logic [31:0] color_c;
	pfa_lookup_t lookup_c;

	logic        valid_s2, oob_s2;
	logic [31:0] color_s2;
	pfa_lookup_t lookup_s2;
	logic [31:0] pal_color;
	logic [31:0] merged;

	logic        valid_s3;
	logic [31:0] argb_s3;
	logic        skid_valid_q;
	logic [31:0] skid_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_RESET;
			use_pal_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FORMAT:      fmt_q     <= cfg_wdata;
				CFG_USE_PALETTE: use_pal_q <= cfg_wdata[0];
				default:         fmt_q     <= fmt_q;
			endcase
		end
	end

	// whole pipeline advances unless the skid buffer is occupied
	assign en = !skid_valid_q;
	assign s_axis_tready = en;

	// s1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			pixel_s1  <= s_axis_tdata[63:0];
			index_s1  <= s_axis_tdata[71:64];
			entry_s1  <= s_axis_tdata[103:72];
		end
	end

	// palette store: writes and reads both issue from s1, so order is kept
	assign ram_en = en && valid_s1;
	assign ram_we = (action_s1 == ACT_PAL_WRITE) && ({1'b0, index_s1} < PAL_LIMIT);
	assign ram_addr = (action_s1 == ACT_PAL_WRITE) ? index_s1[AW-1:0] : pixel_s1[AW-1:0];

	pfa_ram #(
		.WIDTH (32),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (entry_s1),
		.rdata (ram_rdata)
	);

	pfa_unpack u_unpack (
		.fmt         (fmt_q),
		.use_palette (use_pal_q),
		.pixel_word  (pixel_s1),
		.color       (color_c),
		.lookup      (lookup_c)
	);

	// s2: decoded color, lookup control; RAM data lands alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && (action_s1 == ACT_CONVERT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s2  <= color_c;
			lookup_s2 <= lookup_c;
			oob_s2    <= ({1'b0, pixel_s1[7:0]} >= PAL_LIMIT);
		end
	end

	// s3: merge palette data
	assign pal_color = oob_s2 ? 32'h0 : ram_rdata;
	always_comb begin
		if (!lookup_s2.use_ram) begin
			merged = color_s2;
		end else if (lookup_s2.alpha_b1) begin
			merged = {lookup_s2.alpha, pal_color[23:0]};
		end else begin
			merged = pal_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			argb_s3 <= merged;
		end
	end

	// skid buffer catches s3 when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_s3 && !m_axis_tready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && valid_s3 && !m_axis_tready) begin
			skid_data_q <= argb_s3;
		end
	end

	assign m_axis_tvalid = skid_valid_q || valid_s3;
	assign m_axis_tdata  = skid_valid_q ? skid_data_q : argb_s3;

	// palette writes never reach the output side
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s1 && (action_s1 == ACT_PAL_WRITE)) |=> !valid_s2)
		else $error("palette write produced a result");

	// no store write outside the configured depth
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_en && ram_we) |-> ({1'b0, index_s1} < PAL_LIMIT))
		else $error("palette write beyond store");

	// while the skid holds, s3 and its data are frozen
	a_s3_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> ($stable(valid_s3) && $stable(argb_s3) && $stable(ram_rdata)))
		else $error("pipeline moved while skid buffer occupied");

	// a stalled skid entry keeps its data
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !m_axis_tready) |=> (skid_valid_q && $stable(skid_data_q)))
		else $error("skid entry lost under stall");

endmodule

/* sim/tb_pixel_format_to_argb8888_top.sv */
// tb_pixel_format_to_argb8888_top: self-checking bench for the texel-to-ARGB8888 converter.
// Depends on pfa_pkg and pixel_format_to_argb8888_top; a local converter model predicts
// every output transfer, covering directed format sweeps, palette loads and random traffic.
module tb_pixel_format_to_argb8888_top;
	import pfa_pkg::*;

	localparam int PAL_N          = 256;
	localparam int SETTLE_CYCLES  = 8;     // pipeline is 3 deep plus skid buffer
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SEGMENT_ITEMS  = 62;
	localparam int IDLE_PCT       = 59;
	localparam int BOTH_IDLE_PCT  = 9;
	localparam int PAL_WRITE_PCT  = 20;
	localparam int MAX_PRINTS     = 50;

	// codes outside the defined format list
	localparam logic [4:0] FMT_UNUSED_LO = 5'd18;
	localparam logic [4:0] FMT_UNUSED_HI = 5'd31;

	logic          clk;
	logic          arst_n        = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [103:0]  s_axis_tdata  = '0;   // pixel_word[63:0], entry_index[71:64], entry_color[103:72]
	logic          s_axis_tuser  = ACT_CONVERT;  // action
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [31:0]   m_axis_tdata;         // argb
	logic          cfg_we        = 1'b0;
	logic          cfg_index     = CFG_FORMAT;
	logic [4:0]    cfg_wdata     = '0;

	pixel_format_to_argb8888_top #(
		.PALETTE_ENTRIES(PAL_N)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// converter model state
	logic [4:0]   fmt_shadow = FMT_RESET;
	logic         pal_on     = 1'b0;
	logic [31:0]  pal_mirror [PAL_N];
	bit           pal_written [PAL_N];
	logic [7:0]   written_idx [$];
	logic [7:0]   last_written = '0;

	logic [31:0]  argb_expected [$];
	logic [31:0]  argb_want;
	int           err_count    = 0;
	int           quiet_cycles = 0;
	int unsigned  tx_idle_pct  = 0;
	int unsigned  rx_stall_pct = 0;
	logic         rx_hold      = 1'b0;
	event         hold_go;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] grey_of(input logic [7:0] l);
		return {ALPHA_OPAQUE, l, l, l};
	endfunction

	// 3:3:2 widened by bit replication
	function automatic logic [23:0] rgb_from_332(input logic [7:0] b);
		return {b[7:5], b[7:5], b[7:6], b[4:2], b[4:2], b[4:3], {4{b[1:0]}}};
	endfunction

	function automatic logic [31:0] palette_color(input logic [7:0] idx);
		if (!pal_on)
			return grey_of(idx);
		if (idx >= PAL_N)
			return '0;
		return pal_mirror[idx];
	endfunction

	function automatic logic [31:0] argb_from_texel(input logic [63:0] px);
		logic [31:0] lo;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [31:0] col;
		lo = px[31:0];
		b0 = px[7:0];
		b1 = px[15:8];
		case (fmt_shadow)
		FMT_R8G8B8, FMT_X8R8G8B8: return {ALPHA_OPAQUE, lo[23:0]};
		FMT_A8R8G8B8:     return lo;
		FMT_R3G3B2:       return {ALPHA_OPAQUE, rgb_from_332(b0)};
		FMT_A8:           return {b0, 24'hFF_FFFF};
		FMT_A8R3G3B2:     return {b1, rgb_from_332(b0)};
		FMT_A2B10G10R10:  return {{4{lo[31:30]}}, lo[9:2], lo[19:12], lo[29:22]};
		FMT_A8B8G8R8:     return {lo[31:24], lo[7:0], lo[15:8], lo[23:16]};
		FMT_X8B8G8R8:     return {ALPHA_OPAQUE, lo[7:0], lo[15:8], lo[23:16]};
		FMT_G16R16:       return {ALPHA_OPAQUE, lo[15:8], lo[31:24], 8'h00};
		FMT_A2R10G10B10:  return {{4{lo[31:30]}}, lo[29:22], lo[19:12], lo[9:2]};
		FMT_A16B16G16R16: return {px[63:56], b1, px[31:24], px[47:40]};
		FMT_A8L8:         return {b1, b0, b0, b0};
		FMT_A8P8: begin
			col = palette_color(b0);
			return {b1, col[23:0]};
		end
		FMT_L8:           return grey_of(b0);
		FMT_P8:           return palette_color(b0);
		FMT_L16:          return grey_of(b1);
		FMT_A4L4:         return {{2{b0[7:4]}}, {6{b0[3:0]}}};
		default:          return '0;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		if (err_count < MAX_PRINTS)
			$display("argb check failed at %0t: %s", $time, what);
		err_count++;
	endtask

	// one input transfer; model is updated at the accepting edge
	task automatic send_item(input logic act, input logic [63:0] pix, input logic [7:0] idx,
			input logic [31:0] color);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {color, idx, pix};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		if (act == ACT_CONVERT)
			argb_expected.push_back(argb_from_texel(pix));
		else if (idx < PAL_N) begin
			pal_mirror[idx] = color;
			if (!pal_written[idx]) begin
				pal_written[idx] = 1'b1;
				written_idx.push_back(idx);
			end
			last_written = idx;
		end
	endtask

	task automatic send_random_item();
		logic        act;
		logic [63:0] pix;
		act = ($urandom_range(99) < PAL_WRITE_PCT) ? ACT_PAL_WRITE : ACT_CONVERT;
		pix = {$urandom, $urandom};
		// paletted reads only hit loaded entries, often the one just written
		if (act == ACT_CONVERT && pal_on && (fmt_shadow == FMT_P8 || fmt_shadow == FMT_A8P8))
			pix[7:0] = ($urandom_range(3) == 0) ? last_written
				: written_idx[$urandom_range(written_idx.size() - 1)];
		send_item(act, pix, 8'($urandom), $urandom);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (argb_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FORMAT)
			fmt_shadow = val;
		else
			pal_on = val[0];
		@(posedge clk);
	endtask

	task automatic convert_one(input logic [4:0] code, input logic [63:0] pix);
		write_reg(CFG_FORMAT, code);
		send_item(ACT_CONVERT, pix, '0, '0);
		wait_idle();
	endtask

	task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
	endtask

	// reset config, then every format code with the palette off (paletted ones give grey), then two unused codes
	task automatic test_format_sweep();
		logic [63:0] pix;
		send_item(ACT_CONVERT, 64'h8899_AABB_CCDD_EEFF, '0, '0);
		wait_idle();
		write_reg(CFG_USE_PALETTE, 5'd0);
		for (int f = FMT_R8G8B8; f <= FMT_A4L4; f++) begin
			case (f % 3)
			0:       pix = '0;
			1:       pix = '1;
			default: pix = 64'h0123_4567_89AB_CDEF;
			endcase
			convert_one(5'(f), pix);
		end
		convert_one(FMT_UNUSED_LO, '1);
		convert_one(FMT_UNUSED_HI, 64'hFEDC_BA98_7654_3210);
	endtask

	// extreme palette indexes and colors, alpha splice on A8P8
	task automatic test_palette_extremes();
		send_item(ACT_PAL_WRITE, '0, 8'h00, 32'h0000_0000);
		send_item(ACT_PAL_WRITE, '1, 8'hFF, 32'hFFFF_FFFF);
		wait_idle();
		write_reg(CFG_USE_PALETTE, 5'd1);
		convert_one(FMT_P8, 64'h0000_0000_0000_0000);
		convert_one(FMT_P8, 64'hFFFF_FFFF_FFFF_FFFF);
		convert_one(FMT_A8P8, 64'h0000_0000_0000_00FF);
		convert_one(FMT_A8P8, 64'h0000_0000_0000_FF00);
	endtask

	task automatic test_random_traffic();
		int unsigned pick;
		logic [4:0]  code;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
			0:       set_idling(0, 0);
			1:       set_idling(IDLE_PCT, 0);
			2:       set_idling(0, IDLE_PCT);
			default: set_idling(BOTH_IDLE_PCT, BOTH_IDLE_PCT);
			endcase
			for (int seg = 0; seg < 6; seg++) begin
				pick = $urandom_range(9);
				if (pick < 2)
					code = pick[0] ? FMT_P8 : FMT_A8P8;
				else if (pick == 2)
					code = 5'($urandom_range(FMT_UNUSED_HI, FMT_UNUSED_LO));
				else
					code = 5'($urandom_range(FMT_A4L4));
				write_reg(CFG_FORMAT, code);
				write_reg(CFG_USE_PALETTE, 5'($urandom_range(1)));
				repeat (SEGMENT_ITEMS) send_random_item();
				wait_idle();
			end
		end
	endtask

	// output held off while input keeps coming, so the pipe fills and input stalls
	task automatic test_backpressure();
		set_idling(0, 0);
		write_reg(CFG_FORMAT, FMT_A8P8);
		write_reg(CFG_USE_PALETTE, 5'd1);
		-> hold_go;
		repeat (40) send_random_item();
		wait_idle();
	endtask

	always begin
		@(hold_go);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk)
		m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (argb_expected.size() == 0)
				report_mismatch($sformatf("unexpected transfer argb=%08h", m_axis_tdata));
			else begin
				argb_want = argb_expected.pop_front();
				if (m_axis_tdata !== argb_want)
					report_mismatch($sformatf("fmt %0d: got %08h, want %08h",
						fmt_shadow, m_axis_tdata, argb_want));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready === 1'b1)
				|| (m_axis_tvalid === 1'b1 && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_pixel_format_to_argb8888_top: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_format_sweep();
		test_palette_extremes();
		test_random_traffic();
		test_backpressure();
		if (err_count == 0)
			$display("tb_pixel_format_to_argb8888_top: done, clean");
		else
			$display("tb_pixel_format_to_argb8888_top: done, errors");
		$finish;
	end

endmodule
